/* src/tone_pattern_sequencer_macros.svh */
// Assertion helpers for the tone pattern sequencer.
`ifndef TONE_PATTERN_SEQUENCER_MACROS_SVH
`define TONE_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TPS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tone sequencer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tone sequencer check failed");

`endif

/* src/tps_pkg.sv */
`default_nettype none
package tps_pkg;

	localparam int TPS_NUM_PATTERNS = 6;
	localparam int TPS_MAX_STEPS    = 5;
	localparam int TPS_TONE_W       = 12;
	localparam int TPS_MS_W         = 9;
	localparam int TPS_STEP_W       = 3;
	localparam int TPS_PAT_W        = 3;
	localparam int TPS_OP_W         = 2;

	typedef logic [TPS_TONE_W-1:0] tone_t;
	typedef logic [TPS_MS_W-1:0]   ms_t;
	typedef logic [TPS_STEP_W-1:0] step_t;
	typedef logic [TPS_PAT_W-1:0]  pat_t;

	typedef enum logic [TPS_OP_W-1:0] {
		OP_TICK = 2'd0,
		OP_PLAY = 2'd1,
		OP_STOP = 2'd2
	} tps_op_t;

	localparam ms_t ELAPSED_MAX = '1;

	localparam tone_t STEP_HZ [TPS_NUM_PATTERNS][TPS_MAX_STEPS] = '{
		'{12'd2700, 12'd0,    12'd2700, 12'd0, 12'd0},
		'{12'd2200, 12'd1800, 12'd1400, 12'd0, 12'd0},
		'{12'd2000, 12'd0,    12'd2500, 12'd0, 12'd3200},
		'{12'd900,  12'd0,    12'd900,  12'd0, 12'd0},
		'{12'd2700, 12'd0,    12'd2700, 12'd0, 12'd0},
		'{12'd1400, 12'd0,    12'd2400, 12'd0, 12'd0}
	};

	localparam ms_t STEP_MS [TPS_NUM_PATTERNS][TPS_MAX_STEPS] = '{
		'{9'd120, 9'd70,  9'd120, 9'd0,  9'd0},
		'{9'd100, 9'd100, 9'd150, 9'd0,  9'd0},
		'{9'd160, 9'd80,  9'd160, 9'd80, 9'd280},
		'{9'd100, 9'd80,  9'd100, 9'd0,  9'd0},
		'{9'd120, 9'd70,  9'd120, 9'd0,  9'd0},
		'{9'd220, 9'd80,  9'd100, 9'd0,  9'd0}
	};

	localparam step_t SEQ_LEN [TPS_NUM_PATTERNS] = '{
		3'd3, 3'd3, 3'd5, 3'd3, 3'd3, 3'd3
	};

	// Fold a 3-bit pattern code into the table range.
	function automatic pat_t pat_wrap(input pat_t p);
		pat_wrap = (p >= pat_t'(TPS_NUM_PATTERNS)) ? pat_t'(p - pat_t'(TPS_NUM_PATTERNS)) : p;
	endfunction

	// Fold a 3-bit step number into the table range.
	function automatic step_t step_wrap(input step_t s);
		step_wrap = (s >= step_t'(TPS_MAX_STEPS)) ? step_t'(s - step_t'(TPS_MAX_STEPS)) : s;
	endfunction

endpackage
`default_nettype wire

/* src/tone_pattern_sequencer.sv */
// Tone pattern sequencer: plays one of six fixed buzzer patterns.
// Input channel (in_valid/in_ready): each word carries op and pattern.
//   op TICK advances time by one millisecond, PLAY starts a pattern at
//   step 0, STOP silences the buzzer at once; op 3 is ignored.
// Output channel (out_valid/out_ready): one word per input word with the
//   tone now driven (tone_hz, 0 = silent) and the playing flag.
// Config: cfg_wr_en/cfg_wr_data write the enable bit; while it is 0 every
//   word leaves the state untouched but still returns a result.
// Result: registered, and valid in the cycle after its input word is taken.
// Throughput: one word per cycle while results are taken. The whole step
//   update is one level of table lookup, a 9-bit increment and compare,
//   ahead of the state and result registers.
// Stall: in_ready stays high while the result register is empty or being
//   drained this cycle, so a stalled receiver holds the result and blocks
//   only the next word.
// Reset: the buzzer is silent and idle, the enable bit is set, and no
//   result is pending.
`default_nettype none
`include "tone_pattern_sequencer_macros.svh"
module tone_pattern_sequencer (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [tps_pkg::TPS_OP_W-1:0]     op,
	input  wire  [tps_pkg::TPS_PAT_W-1:0]    pattern,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [tps_pkg::TPS_TONE_W-1:0]   tone_hz,
	output logic                             playing,
	input  wire                              cfg_wr_en,
	input  wire                              cfg_wr_data
);
	import tps_pkg::*;

	logic  enabled_q;
	logic  active_q,  active_d;
	pat_t  pat_q,     pat_d;
	step_t step_q,    step_d;
	ms_t   elapsed_q, elapsed_d;
	tone_t tone_q,    tone_d;

	logic  out_valid_q;
	tone_t out_tone_q;
	logic  out_playing_q;

	logic  in_fire;
	pat_t  p_cur;
	step_t s_cur;
	step_t s_nxt;
	ms_t   el_inc;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign p_cur  = pat_wrap(pat_q);
	assign s_cur  = step_wrap(step_q);
	assign s_nxt  = step_t'(s_cur + step_t'(1));
	assign el_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : ms_t'(elapsed_q + ms_t'(1));

	always_comb begin
		active_d  = active_q;
		pat_d     = pat_q;
		step_d    = step_q;
		elapsed_d = elapsed_q;
		tone_d    = tone_q;
		if (in_fire && enabled_q) begin
			unique case (op)
				OP_PLAY: begin
					if (pattern < pat_t'(TPS_NUM_PATTERNS)) begin
						pat_d     = pattern;
						step_d    = '0;
						active_d  = 1'b1;
						tone_d    = STEP_HZ[pattern][0];
						elapsed_d = '0;
					end
				end
				OP_STOP: begin
					tone_d   = '0;
					active_d = 1'b0;
				end
				OP_TICK: begin
					if (active_q) begin
						elapsed_d = el_inc;
						if (el_inc >= STEP_MS[p_cur][s_cur]) begin
							step_d = s_nxt;
							// past the last step: go silent and idle
							if (s_nxt >= SEQ_LEN[p_cur]) begin
								tone_d   = '0;
								active_d = 1'b0;
							end else begin
								tone_d    = STEP_HZ[p_cur][s_nxt];
								elapsed_d = '0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			active_q  <= 1'b0;
			pat_q     <= '0;
			step_q    <= '0;
			elapsed_q <= '0;
			tone_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				enabled_q <= cfg_wr_data;
			end
			active_q  <= active_d;
			pat_q     <= pat_d;
			step_q    <= step_d;
			elapsed_q <= elapsed_d;
			tone_q    <= tone_d;
		end
	end

	// result register: load on accept, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_tone_q    <= tone_d;
			out_playing_q <= active_d;
		end
	end

	assign out_valid = out_valid_q;
	assign tone_hz   = out_tone_q;
	assign playing   = out_playing_q;

	`TPS_ASSERT_SAME(a_idle_silent, !active_q, tone_q == '0)
	`TPS_ASSERT_SAME(a_step_in_range, active_q, step_q < SEQ_LEN[p_cur])
	`TPS_ASSERT_SAME(a_elapsed_below_dur, active_q, elapsed_q < STEP_MS[p_cur][s_cur])
	`TPS_ASSERT_NEXT(a_disabled_frozen, in_fire && !enabled_q, $stable(active_q) && $stable(tone_q) && $stable(step_q) && $stable(elapsed_q))
	`TPS_ASSERT_NEXT(a_result_follows, in_fire, out_valid_q && (out_tone_q == tone_q) && (out_playing_q == active_q))

endmodule
`default_nettype wire
